// ----- sv/ptc_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ptc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_STEPS  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9   = CFG_IDX_W'(3);

    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic signed [35:0] TEMP_MUL    = 36'sd5;
    localparam logic signed [35:0] TEMP_RND    = 36'sd128;
    localparam logic [63:0]        DEN_BIAS    = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_calib;

    // Side data that rides along with the division.
    typedef struct packed {
        logic signed [31:0] temp;
        logic               invalid;
    } t_tag;

endpackage

// ----- sv/ptc_temp.sv -----
// Temperature front end: two stages forming the fine temperature.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_temp import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_calib             i_calib,
    input  logic               i_valid,
    input  logic        [19:0] i_raw_t,
    input  logic        [19:0] i_raw_p,
    output logic               o_valid,
    output logic signed [31:0] o_fine,
    output logic        [19:0] o_raw_p
);

    logic signed [17:0] w_a;
    logic signed [17:0] w_b;
    logic signed [33:0] n_at2;
    logic signed [35:0] n_bb;
    logic signed [33:0] r_at2;
    logic signed [35:0] r_bb;
    logic        [19:0] r_raw_p1;
    logic               r_valid1;

    logic signed [21:0] w_bbs;
    logic signed [37:0] w_m3;
    logic signed [33:0] w_v1;
    logic signed [37:0] w_v2;
    logic signed [31:0] n_fine;
    logic signed [31:0] r_fine;
    logic        [19:0] r_raw_p2;
    logic               r_valid2;

    always_comb begin
        w_a   = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_calib.t1, 1'b0});
        w_b   = $signed({2'b0, i_raw_t[19:4]}) - $signed({2'b0, i_calib.t1});
        n_at2 = w_a * $signed(i_calib.t2);
        n_bb  = w_b * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_at2    <= n_at2;
            r_bb     <= n_bb;
            r_raw_p1 <= i_raw_p;
            r_fine   <= n_fine;
            r_raw_p2 <= r_raw_p1;
        end
    end

    // b*b is below 2^32, so the shifted square is a small positive value
    always_comb begin
        w_bbs  = $signed(r_bb[33:12]);
        w_m3   = w_bbs * $signed(i_calib.t3);
        w_v1   = r_at2 >>> 11;
        w_v2   = w_m3 >>> 14;
        n_fine = 32'(38'(w_v1) + w_v2);
    end

    assign o_valid = r_valid2;
    assign o_fine  = r_fine;
    assign o_raw_p = r_raw_p2;

endmodule

// ----- sv/ptc_poly.sv -----
// Pressure polynomial: five stages from the fine temperature to the
// numerator and divisor of the pressure division. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_poly import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_calib             i_calib,
    input  logic               i_valid,
    input  logic signed [31:0] i_fine,
    input  logic        [19:0] i_raw_p,
    output logic               o_valid,
    output logic signed [31:0] o_temp,
    output logic        [63:0] o_num,
    output logic        [63:0] o_den
);

    logic [4:0] r_valid;

    // stage 3
    logic signed [35:0] w_t5;
    logic signed [32:0] w_pv1;
    logic signed [65:0] w_sq;
    logic signed [31:0] r3_temp;
    logic        [63:0] r3_sq;
    logic signed [48:0] r3_m5;
    logic signed [48:0] r3_m2;
    logic        [19:0] r3_raw_p;

    // stage 4
    logic signed [79:0] w_m6;
    logic signed [79:0] w_m3;
    logic signed [31:0] r4_temp;
    logic        [63:0] r4_m6;
    logic        [63:0] r4_m3;
    logic signed [48:0] r4_m5;
    logic signed [48:0] r4_m2;
    logic        [19:0] r4_raw_p;

    // stage 5
    logic signed [31:0] r5_temp;
    logic        [63:0] r5_v2;
    logic        [63:0] r5_v1a;
    logic        [19:0] r5_raw_p;

    // stage 6
    logic        [63:0] w_bsum;
    logic        [79:0] w_bprod;
    logic        [20:0] w_pd;
    logic signed [31:0] r6_temp;
    logic        [63:0] r6_v1b;
    logic        [63:0] r6_diff;

    // stage 7
    logic        [75:0] w_num;
    logic signed [31:0] r7_temp;
    logic        [63:0] r7_num;
    logic        [63:0] r7_den;

    always_comb begin
        w_t5  = 36'(i_fine) * TEMP_MUL + TEMP_RND;
        w_pv1 = 33'(i_fine) - FINE_OFFSET;
        w_sq  = w_pv1 * w_pv1;
        w_m6  = $signed(r3_sq) * $signed(i_calib.p6);
        w_m3  = $signed(r3_sq) * $signed(i_calib.p3);
        w_bsum  = r5_v1a + DEN_BIAS;
        w_bprod = w_bsum * i_calib.p1;
        w_pd    = PRESS_FULL - {1'b0, r5_raw_p};
        w_num   = r6_diff * PRESS_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_temp  <= 32'(w_t5 >>> 8);
            r3_sq    <= w_sq[63:0];
            r3_m5    <= w_pv1 * $signed(i_calib.p5);
            r3_m2    <= w_pv1 * $signed(i_calib.p2);
            r3_raw_p <= i_raw_p;

            r4_temp  <= r3_temp;
            r4_m6    <= w_m6[63:0];
            r4_m3    <= w_m3[63:0];
            r4_m5    <= r3_m5;
            r4_m2    <= r3_m2;
            r4_raw_p <= r3_raw_p;

            r5_temp  <= r4_temp;
            r5_v2    <= r4_m6 + (64'(r4_m5) << 17) + (64'(i_calib.p4) << 35);
            r5_v1a   <= 64'($signed(r4_m3) >>> 8) + (64'(r4_m2) << 12);
            r5_raw_p <= r4_raw_p;

            r6_temp  <= r5_temp;
            r6_v1b   <= w_bprod[63:0];
            r6_diff  <= (64'(w_pd) << 31) - r5_v2;

            r7_temp  <= r6_temp;
            r7_num   <= w_num[63:0];
            r7_den   <= 64'($signed(r6_v1b) >>> 33);
        end
    end

    assign o_valid = r_valid[4];
    assign o_temp  = r7_temp;
    assign o_num   = r7_num;
    assign o_den   = r7_den;

endmodule

// ----- sv/ptc_div.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating
// toward zero. Carries the temperature and invalid flag alongside. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_div import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_temp,
    input  logic        [63:0] i_num,
    input  logic        [63:0] i_den,
    output logic               o_valid,
    output t_tag               o_tag,
    output logic        [63:0] o_quo
);

    logic [63:0] r_rem [0:DIV_STEPS];
    logic [63:0] r_quo [0:DIV_STEPS];
    logic [63:0] r_dvs [0:DIV_STEPS];
    logic        r_neg [0:DIV_STEPS];
    t_tag        r_tag [0:DIV_STEPS];
    logic        r_vld [0:DIV_STEPS];

    logic [63:0] r_out_quo;
    t_tag        r_out_tag;
    logic        r_out_vld;

    // prep stage: take magnitudes and note the sign of the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]         <= '0;
            r_quo[0]         <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_dvs[0]         <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg[0]         <= i_num[63] ^ i_den[63];
            r_tag[0].temp    <= i_temp;
            r_tag[0].invalid <= (i_den == 64'd0);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] w_sh;
        logic [64:0] w_df;
        logic [63:0] n_rem;
        logic [63:0] n_quo;

        // remainder stays below the divisor, at most 2^63, so the shift fits
        always_comb begin
            w_sh = {r_rem[k][62:0], r_quo[k][63]};
            w_df = {1'b0, w_sh} - {1'b0, r_dvs[k]};
            if (!w_df[64]) begin
                n_rem = w_df[63:0];
                n_quo = {r_quo[k][62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[k][62:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_quo[k+1] <= n_quo;
                r_dvs[k+1] <= r_dvs[k];
                r_neg[k+1] <= r_neg[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo <= r_neg[DIV_STEPS] ? (64'd0 - r_quo[DIV_STEPS]) : r_quo[DIV_STEPS];
            r_out_tag <= r_tag[DIV_STEPS];
        end
    end

    assign o_valid = r_out_vld;
    assign o_tag   = r_out_tag;
    assign o_quo   = r_out_quo;

endmodule

// ----- sv/ptc_post.sv -----
// Pressure back end: four stages of correction terms after the division,
// the last being the output register. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_post import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_calib             i_calib,
    input  logic               i_valid,
    input  t_tag               i_tag,
    input  logic        [63:0] i_quo,
    output logic               o_valid,
    output logic signed [31:0] o_temp,
    output logic        [23:0] o_press,
    output logic               o_invalid
);

    logic [3:0] r_valid;

    // stage 1: partial products of x*x with x = q >>> 13, and p8*q
    logic        [63:0] w_x;
    logic signed [79:0] w_m8;
    logic        [63:0] r1_pp0;
    logic        [31:0] r1_pp1;
    logic        [63:0] r1_m8;
    logic        [63:0] r1_q;
    t_tag               r1_tag;

    // stage 2
    logic        [63:0] r2_xx;
    logic        [63:0] r2_v2;
    logic        [63:0] r2_q;
    t_tag               r2_tag;

    // stage 3
    logic signed [79:0] w_m9;
    logic        [63:0] r3_m9;
    logic        [63:0] r3_v2;
    logic        [63:0] r3_q;
    t_tag               r3_tag;

    // stage 4
    logic        [63:0] w_sum;
    logic        [31:0] w_p32;
    logic signed [31:0] r4_temp;
    logic        [23:0] r4_press;
    logic               r4_invalid;

    always_comb begin
        w_x   = 64'($signed(i_quo) >>> 13);
        w_m8  = $signed(i_quo) * $signed(i_calib.p8);
        w_m9  = $signed(r2_xx) * $signed(i_calib.p9);
        w_sum = r3_q + 64'($signed(r3_m9) >>> 25) + r3_v2;
        w_p32 = w_sum[39:8] + (32'(i_calib.p7) << 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pp0 <= w_x[31:0] * w_x[31:0];
            r1_pp1 <= 32'(w_x[63:32] * w_x[31:0]);
            r1_m8  <= w_m8[63:0];
            r1_q   <= i_quo;
            r1_tag <= i_tag;

            // both cross terms are equal for a square
            r2_xx  <= r1_pp0 + {r1_pp1[30:0], 33'd0};
            r2_v2  <= 64'($signed(r1_m8) >>> 19);
            r2_q   <= r1_q;
            r2_tag <= r1_tag;

            r3_m9  <= w_m9[63:0];
            r3_v2  <= r2_v2;
            r3_q   <= r2_q;
            r3_tag <= r2_tag;

            r4_temp    <= r3_tag.temp;
            r4_press   <= r3_tag.invalid ? 24'd0 : w_p32[31:8];
            r4_invalid <= r3_tag.invalid;
        end
    end

    assign o_valid   = r_valid[3];
    assign o_temp    = r4_temp;
    assign o_press   = r4_press;
    assign o_invalid = r4_invalid;

endmodule

// ----- sv/pressure_temperature_compensation.sv -----
// Top level of the pressure/temperature compensation block: calibration
// registers and the pipeline chain. Depends on ptc_pkg and all ptc_ modules.
`timescale 1ns / 1ps
// Takes one raw temperature/pressure pair per cycle while o_ready is high and
// returns temperature in 0.01 degC and pressure in Pa, one result per item, in
// order. The pipeline has 2 temperature stages, 5 polynomial stages, 66 divider
// stages (sign prep, 64 one-bit restoring steps, sign fixup) and 4 back-end
// stages ending in the output register. Throughput is one item per clock while
// the output is not stalled. When the output holds an untaken result the whole
// pipeline holds and i_ready-side o_ready drops. A zero divisor gives pressure
// 0 with o_pressure_invalid set. Write calibration only while the pipe is empty.
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [19:0]           i_raw_temperature,
    input  logic [19:0]           i_raw_pressure,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_temperature_centi,
    output logic [23:0]           o_pressure_pa,
    output logic                  o_pressure_invalid
);

    t_calib r_calib;
    logic   w_en;

    logic               w_t_valid;
    logic signed [31:0] w_fine;
    logic        [19:0] w_raw_p;
    logic               w_p_valid;
    logic signed [31:0] w_temp;
    logic        [63:0] w_num;
    logic        [63:0] w_den;
    logic               w_d_valid;
    t_tag               w_tag;
    logic        [63:0] w_quo;

    // advance everything unless a finished result is waiting
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMP_CALIB: begin
                    r_calib.t1 <= i_cfg_wdata[15:0];
                    r_calib.t2 <= i_cfg_wdata[31:16];
                    r_calib.t3 <= i_cfg_wdata[47:32];
                end
                REG_PRESS_LOW: begin
                    r_calib.p1 <= i_cfg_wdata[15:0];
                    r_calib.p2 <= i_cfg_wdata[31:16];
                    r_calib.p3 <= i_cfg_wdata[47:32];
                    r_calib.p4 <= i_cfg_wdata[63:48];
                end
                REG_PRESS_HIGH: begin
                    r_calib.p5 <= i_cfg_wdata[15:0];
                    r_calib.p6 <= i_cfg_wdata[31:16];
                    r_calib.p7 <= i_cfg_wdata[47:32];
                    r_calib.p8 <= i_cfg_wdata[63:48];
                end
                REG_PRESS_P9: begin
                    r_calib.p9 <= i_cfg_wdata[15:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    ptc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_calib (r_calib),
        .i_valid (i_valid),
        .i_raw_t (i_raw_temperature),
        .i_raw_p (i_raw_pressure),
        .o_valid (w_t_valid),
        .o_fine  (w_fine),
        .o_raw_p (w_raw_p)
    );

    ptc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_calib (r_calib),
        .i_valid (w_t_valid),
        .i_fine  (w_fine),
        .i_raw_p (w_raw_p),
        .o_valid (w_p_valid),
        .o_temp  (w_temp),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_temp  (w_temp),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_valid (w_d_valid),
        .o_tag   (w_tag),
        .o_quo   (w_quo)
    );

    ptc_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_calib   (r_calib),
        .i_valid   (w_d_valid),
        .i_tag     (w_tag),
        .i_quo     (w_quo),
        .o_valid   (o_valid),
        .o_temp    (o_temperature_centi),
        .o_press   (o_pressure_pa),
        .o_invalid (o_pressure_invalid)
    );

endmodule

// ----- sv/ptc_checker.sv -----
// Port-level checks for the compensation block, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps
module ptc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic signed [31:0]    o_temperature_centi,
    input logic [23:0]           o_pressure_pa,
    input logic                  o_pressure_invalid
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_temperature_centi)
            && $stable(o_pressure_pa) && $stable(o_pressure_invalid))
        else $error("result changed while stalled");

    // input side stalls only behind an untaken result
    a_ready: assert property (@(posedge i_clk)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output backpressure");

    // a zero divisor forces zero pressure
    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_pa == 24'd0)
        else $error("invalid pressure not zero");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

// ----- verif/tb_pressure_temperature_compensation.sv -----
// Self-checking testbench for pressure_temperature_compensation.
// Predicts every result from its own copy of the calibration; depends on ptc_pkg and the block.
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] temp;
    logic [23:0] pa;
    logic        inv;
} t_comp_result;

class comp_scoreboard;
    logic [63:0]  temp_calib;
    logic [63:0]  press_low;
    logic [63:0]  press_high;
    logic [63:0]  press_p9;
    t_comp_result pending_q[$];
    int           errors;

    function new();
        temp_calib = '0;
        press_low  = '0;
        press_high = '0;
        press_p9   = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] val);
        case (idx)
            ptc_pkg::REG_TEMP_CALIB: temp_calib = val & 64'hFFFF_FFFF_FFFF;
            ptc_pkg::REG_PRESS_LOW:  press_low  = val;
            ptc_pkg::REG_PRESS_HIGH: press_high = val;
            ptc_pkg::REG_PRESS_P9:   press_p9   = val & 64'hFFFF;
            default: ;
        endcase
    endfunction

    static function logic [63:0] sx16(logic [63:0] v);
        return {{48{v[15]}}, v[15:0]};
    endfunction

    static function logic [63:0] asr(logic [63:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    static function logic [63:0] sdiv(logic [63:0] num, logic [63:0] den);
        logic [63:0] mn, md, q;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q  = mn / md;
        return (num[63] ^ den[63]) ? -q : q;
    endfunction

    function t_comp_result compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        t_comp_result r;
        logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, v1, v2, fine, p;
        adc_t = {44'd0, raw_t};
        adc_p = {44'd0, raw_p};
        t1 = {48'd0, temp_calib[15:0]};
        t2 = sx16(temp_calib >> 16);
        t3 = sx16(temp_calib >> 32);
        p1 = {48'd0, press_low[15:0]};
        p2 = sx16(press_low >> 16);
        p3 = sx16(press_low >> 32);
        p4 = sx16(press_low >> 48);
        p5 = sx16(press_high);
        p6 = sx16(press_high >> 16);
        p7 = sx16(press_high >> 32);
        p8 = sx16(press_high >> 48);
        p9 = sx16(press_p9);

        a    = (adc_t >> 3) - (t1 << 1);
        v1   = asr(a * t2, 11);
        b    = (adc_t >> 4) - t1;
        v2   = asr(asr(b * b, 12) * t3, 14);
        fine = v1 + v2;
        r.temp = 32'(asr(fine * 64'd5 + 64'd128, 8));

        v1 = fine - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 0) begin
            r.pa  = '0;
            r.inv = 1'b1;
        end else begin
            p  = 64'd1048576 - adc_p;
            p  = sdiv(((p << 31) - v2) * 64'd3125, v1);
            v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
            v2 = asr(p8 * p, 19);
            p  = asr(p + v1 + v2, 8) + (p7 << 4);
            r.pa  = p[31:8];
            r.inv = 1'b0;
        end
        return r;
    endfunction

    function void note_item(logic [19:0] raw_t, logic [19:0] raw_p);
        pending_q.push_back(compensate(raw_t, raw_p));
    endfunction

    function void check_result(logic [31:0] temp, logic [23:0] pa, logic inv);
        t_comp_result e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result temp=%0d pa=%0d inv=%0b", $time,
                     $signed(temp), pa, inv);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (e.temp !== temp) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(e.temp), $signed(temp));
            errors++;
        end
        if (e.pa !== pa) begin
            $display("%0t: pressure expected %0d actual %0d", $time, e.pa, pa);
            errors++;
        end
        if (e.inv !== inv) begin
            $display("%0t: invalid flag expected %0b actual %0b", $time, e.inv, inv);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(255);
    localparam int DRAIN_CYCLES = 90;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [19:0]           i_raw_temperature;
    logic [19:0]           i_raw_pressure;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [31:0]    o_temperature_centi;
    logic [23:0]           o_pressure_pa;
    logic                  o_pressure_invalid;

    comp_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    pressure_temperature_compensation u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("** pressure_temperature_compensation: FAILED **");
        $finish;
    end

    // Output side: check every accepted result, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_temperature_centi, o_pressure_pa, o_pressure_invalid);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_calib(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                              logic [63:0] p9);
        cfg_write(REG_TEMP_CALIB, tc);
        cfg_write(REG_PRESS_LOW, pl);
        cfg_write(REG_PRESS_HIGH, ph);
        cfg_write(REG_PRESS_P9, p9);
    endtask

    task automatic send_item(logic [19:0] raw_t, logic [19:0] raw_p);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure    <= raw_p;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(raw_t, raw_p);
    endtask

    // Hold the input low until every expected result is back, then let the pipe settle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly readings near a real operating point, the rest anywhere in range.
    task automatic send_random(int n);
        logic [19:0] rt, rp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 75) begin
                rt = 20'd400000 + 20'($urandom_range(250000));
                rp = 20'd250000 + 20'($urandom_range(350000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end
            send_item(rt, rp);
        end
    endtask

    function automatic logic [63:0] near_calib(logic [63:0] base);
        logic [63:0] v;
        v = base;
        for (int f = 0; f < 4; f++)
            v[f*16 +: 16] = v[f*16 +: 16] + 16'($urandom_range(64)) - 16'd32;
        return v;
    endfunction

    localparam logic [63:0] TC_TYP = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] PL_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] PH_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] P9_TYP = 64'd6000;

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: P1 is zero, so every divisor is zero.
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd519888, 20'd415148);
        drain();

        load_calib(TC_TYP, PL_TYP, PH_TYP, P9_TYP);
        // Writes to unused indexes must leave the calibration alone.
        cfg_write(REG_UNUSED, 64'hDEAD_BEEF_0123_4567);
        cfg_write(REG_TOP, '1);
        send_item(20'd519888, 20'd415148);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'd0);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h80000, 20'h7FFFF);
        drain();

        // All fields at their extremes; upper bits of the narrow registers are dropped.
        load_calib('1, '1, '1, '1);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'hFFFFF, 20'd0);
        send_item(20'd519888, 20'd415148);
        drain();
        load_calib({16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                   {16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'h7FFF);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd519888, 20'd415148);
        drain();
        load_calib(TC_TYP, {PL_TYP[63:16], 16'd0}, PH_TYP, 64'h8000);
        send_item(20'd519888, 20'd415148);
        send_item(20'hFFFFF, 20'h12345);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 2)
                load_calib({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            else
                load_calib(near_calib(TC_TYP), near_calib(PL_TYP),
                           near_calib(PH_TYP), near_calib(P9_TYP));
            send_random(60);
            drain();
            send_random(60);
            drain();
        end

        // Long receiver hold-off with the sender pushing flat out.
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        load_calib(TC_TYP, PL_TYP, PH_TYP, P9_TYP);
        hold_cycles = 400;
        send_random(120);
        drain();

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** pressure_temperature_compensation: PASSED **");
        else
            $display("** pressure_temperature_compensation: FAILED **");
        $finish;
    end
endmodule
